@@ rtl/ddo_pkg.sv @@
package ddo_pkg;

  localparam int TRIG_ITERATIONS_DEF = 24;
  localparam int POS_FRAC_BITS_DEF   = 16;

  // command kinds carried in the input tuser
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_INIT   = 2'd2;

  // register reset values
  localparam logic [31:0] DIST_PER_COUNT_RST     = 32'd429497;
  localparam logic [23:0] INV_WHEEL_BASE_RST     = 24'd218453;
  localparam logic [28:0] STRAIGHT_THRESHOLD_RST = 29'd536871;

  // angles in Q3.29
  localparam logic signed [34:0] PI_Q29      = 35'sd1686629713;
  localparam logic signed [34:0] HALF_PI_Q29 = 35'sd843314857;
  localparam logic signed [34:0] TWO_PI_Q29  = 35'sd3373259426;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;

  // datapath operations
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_CLEAR  = 5'd1;
  localparam logic [4:0] OP_INIT   = 5'd2;
  localparam logic [4:0] OP_DELTA  = 5'd3;
  localparam logic [4:0] OP_MUL_L  = 5'd4;
  localparam logic [4:0] OP_MUL_R  = 5'd5;
  localparam logic [4:0] OP_DIST_R = 5'd6;
  localparam logic [4:0] OP_PREP   = 5'd7;
  localparam logic [4:0] OP_HLO    = 5'd8;
  localparam logic [4:0] OP_HHI    = 5'd9;
  localparam logic [4:0] OP_HSUM   = 5'd10;
  localparam logic [4:0] OP_WFIN   = 5'd11;
  localparam logic [4:0] OP_T0_GO  = 5'd12;
  localparam logic [4:0] OP_T0_CAP = 5'd13;
  localparam logic [4:0] OP_T1_GO  = 5'd14;
  localparam logic [4:0] OP_T1_CAP = 5'd15;
  localparam logic [4:0] OP_MUL_NX = 5'd16;
  localparam logic [4:0] OP_MUL_NY = 5'd17;
  localparam logic [4:0] OP_NY_CAP = 5'd18;
  localparam logic [4:0] OP_DX_GO  = 5'd19;
  localparam logic [4:0] OP_DX_CAP = 5'd20;
  localparam logic [4:0] OP_DY_GO  = 5'd21;
  localparam logic [4:0] OP_DY_CAP = 5'd22;
  localparam logic [4:0] OP_MUL_SX = 5'd23;
  localparam logic [4:0] OP_MUL_SY = 5'd24;
  localparam logic [4:0] OP_SY_CAP = 5'd25;
  localparam logic [4:0] OP_OUT    = 5'd26;

  typedef struct packed {
    logic       load;
    logic [4:0] op;
  } ddo_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       dt_pos;
    logic       arc;
    logic       trig_done;
    logic       div_done;
  } ddo_stat_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sh3243F6A8;
      5'd1:  r = 32'sh1DAC6705;
      5'd2:  r = 32'sh0FADBAFC;
      5'd3:  r = 32'sh07F56EA6;
      5'd4:  r = 32'sh03FEAB76;
      5'd5:  r = 32'sh01FFD55B;
      5'd6:  r = 32'sh00FFFAAA;
      5'd7:  r = 32'sh007FFF55;
      5'd8:  r = 32'sh003FFFEA;
      5'd9:  r = 32'sh001FFFFD;
      5'd10: r = 32'sh000FFFFF;
      5'd11: r = 32'sh0007FFFF;
      5'd12: r = 32'sh0003FFFF;
      5'd13: r = 32'sh0001FFFF;
      5'd14: r = 32'sh0000FFFF;
      5'd15: r = 32'sh00007FFF;
      5'd16: r = 32'sh00003FFF;
      5'd17: r = 32'sh00001FFF;
      5'd18: r = 32'sh00000FFF;
      5'd19: r = 32'sh000007FF;
      5'd20: r = 32'sh000003FF;
      5'd21: r = 32'sh000001FF;
      5'd22: r = 32'sh000000FF;
      5'd23: r = 32'sh0000007F;
      5'd24: r = 32'sh0000003F;
      5'd25: r = 32'sh0000001F;
      5'd26: r = 32'sh0000000F;
      5'd27: r = 32'sh00000008;
      5'd28: r = 32'sh00000004;
      5'd29: r = 32'sh00000002;
      5'd30: r = 32'sh00000001;
      default: r = 32'sh00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    logic signed [31:0] r;
    if (a > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (a < -64'sd2147483648) r = 32'sh80000000;
    else r = a[31:0];
    return r;
  endfunction

  // argument stays within one turn beyond [-pi, pi) on either side
  function automatic logic signed [31:0] wrap_angle(input logic signed [34:0] a);
    logic signed [34:0] m;
    m = a + PI_Q29;
    if (m < 0) m = m + TWO_PI_Q29;
    else if (m >= TWO_PI_Q29) m = m - TWO_PI_Q29;
    m = m - PI_Q29;
    return m[31:0];
  endfunction

endpackage

@@ rtl/differential_drive_odometry.sv @@
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tuser: cmd; tdata: left, right, time_ms
// m_axis    out  m_axis_tvalid/tready       tuser: updated; tdata: x, y, heading
// apb       in   psel/penable/pwrite/pready dist_per_count, inv_wheel_base, threshold
//
// one item at a time; clear, initialize and unused commands go from decode to the result
// register, a sample with no time advance by way of the time check
// a straight update runs the multiplier, heading steps and one iterative cordic pass, an
// arc update two cordic passes and two runs of the 33-step divider
// a new item is taken while the previous result still waits in the output register
// synchronous reset restores register defaults and zeroes pose and stored sample
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF,
  parameter int POS_FRAC_BITS   = POS_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // left_count, right_count, time_ms
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // pose_x, pose_y, heading
  output logic [0:0]  m_axis_tuser,   // updated
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_DIST_PER_COUNT = 2'd0;
  localparam logic [1:0] REG_INV_WHEEL_BASE = 2'd1;
  localparam logic [1:0] REG_STRAIGHT_THR   = 2'd2;

  logic [31:0] dist_per_count;
  logic [23:0] inv_wheel_base;
  logic [28:0] straight_threshold;

  ddo_cmd_t  cmd;
  ddo_stat_t stat;
  logic signed [31:0] out_x, out_y, out_heading;
  logic               out_updated;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count     <= DIST_PER_COUNT_RST;
      inv_wheel_base     <= INV_WHEEL_BASE_RST;
      straight_threshold <= STRAIGHT_THRESHOLD_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_DIST_PER_COUNT: dist_per_count     <= pwdata;
        REG_INV_WHEEL_BASE: inv_wheel_base     <= pwdata[23:0];
        REG_STRAIGHT_THR:   straight_threshold <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIST_PER_COUNT: prdata = dist_per_count;
      REG_INV_WHEEL_BASE: prdata = 32'(inv_wheel_base);
      REG_STRAIGHT_THR:   prdata = 32'(straight_threshold);
      default:            prdata = '0;
    endcase
  end

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ddo_datapath #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS),
    .POS_FRAC_BITS   (POS_FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (s_axis_tuser),
    .in_left            (s_axis_tdata[31:0]),
    .in_right           (s_axis_tdata[63:32]),
    .in_time            (s_axis_tdata[95:64]),
    .dist_per_count     (dist_per_count),
    .inv_wheel_base     (inv_wheel_base),
    .straight_threshold (straight_threshold),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_heading        (out_heading),
    .out_updated        (out_updated)
  );

  assign m_axis_tdata = {out_heading, out_y, out_x};
  assign m_axis_tuser = out_updated;

endmodule

@@ rtl/ddo_cordic.sv @@
module ddo_cordic import ddo_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [34:0] angle,
  output logic               done,
  output logic signed [31:0] sin_out,
  output logic signed [31:0] cos_out
);

  localparam int IW = $clog2(TRIG_ITERATIONS);

  logic              busy;
  logic [IW-1:0]     cnt;
  logic signed [31:0] x, y, z;
  logic              neg;

  logic signed [32:0] a_w, a_f;
  logic               n_f;
  logic signed [31:0] dx, dy, at;

  always_comb begin
    a_w = 33'(wrap_angle(angle));
    a_f = a_w;
    n_f = 1'b0;
    // fold into the right half plane
    if (a_w > 33'(HALF_PI_Q29)) begin
      a_f = a_w - 33'(PI_Q29);
      n_f = 1'b1;
    end else if (a_w < -33'(HALF_PI_Q29)) begin
      a_f = a_w + 33'(PI_Q29);
      n_f = 1'b1;
    end
    dx = y >>> cnt;
    dy = x >>> cnt;
    at = atan_q30(5'(cnt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= a_f[31:0] <<< 1;
        neg  <= n_f;
      end else if (busy) begin
        if (!z[31]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        if (cnt == IW'(TRIG_ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign sin_out = neg ? -y : y;
  assign cos_out = neg ? -x : x;

endmodule

@@ rtl/ddo_divider.sv @@
module ddo_divider import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [64:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic [32:0]        quot,
  output logic               qneg,
  output logic               ovf
);

  localparam int QB = 33;

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [32:0] nlo;
  logic [32:0] dmag;

  logic [64:0] nmag_w;
  logic [32:0] dmag_w;
  logic [33:0] r2;

  always_comb begin
    nmag_w = num[64] ? 65'(-num) : 65'(num);
    dmag_w = den[32] ? 33'(-den) : 33'(den);
    r2     = {rem, nlo[QB-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        // quotient needs more than QB bits: caller saturates
        ovf  <= 33'(nmag_w[63:QB]) >= dmag_w;
        qneg <= num[64] ^ den[32];
        dmag <= dmag_w;
        rem  <= 33'(nmag_w[63:QB]);
        nlo  <= nmag_w[QB-1:0];
        quot <= '0;
      end else if (busy) begin
        nlo <= nlo << 1;
        if (r2 >= {1'b0, dmag}) begin
          rem  <= 33'(r2 - {1'b0, dmag});
          quot <= {quot[31:0], 1'b1};
        end else begin
          rem  <= r2[32:0];
          quot <= {quot[31:0], 1'b0};
        end
        if (cnt == 6'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/ddo_datapath.sv @@
module ddo_datapath import ddo_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF,
  parameter int POS_FRAC_BITS   = POS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ddo_cmd_t           cmd,
  output ddo_stat_t          stat,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_left,
  input  logic [31:0]        in_right,
  input  logic [31:0]        in_time,
  input  logic [31:0]        dist_per_count,
  input  logic [23:0]        inv_wheel_base,
  input  logic [28:0]        straight_threshold,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_heading,
  output logic               out_updated
);

  localparam int SH     = 32 - POS_FRAC_BITS;
  localparam int DIST_W = 32 + POS_FRAC_BITS;
  localparam int AW     = DIST_W + 1;
  localparam int WA     = POS_FRAC_BITS + 18;
  localparam int HALF   = (WA + 1) / 2;
  localparam int HI     = WA - HALF;
  localparam int PW     = WA + 24;
  localparam int WSH_R  = (POS_FRAC_BITS >= 13) ? POS_FRAC_BITS - 13 : 0;
  localparam int WSH_L  = (POS_FRAC_BITS >= 13) ? 0 : 13 - POS_FRAC_BITS;

  logic [1:0]  kind;
  logic [31:0] lin, rin, tin;
  logic [31:0] prev_left, prev_right, prev_time;
  logic signed [31:0] pos_x_reg, pos_y_reg, heading_reg;
  logic        upd, dt_pos;
  logic signed [31:0] dl, dr;
  logic signed [65:0] prod;
  logic signed [DIST_W-1:0] dist_l, dist_r;
  logic signed [31:0] v;
  logic [AW-1:0]      a_abs;
  logic               dneg, hsat_pre;
  logic [HALF+23:0]   plo;
  logic [PW-1:0]      p_sum;
  logic signed [31:0] w;
  logic               arc;
  logic signed [31:0] s0, c0, s1, c1;
  logic signed [64:0] numx, numy;

  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] dt_w;
  logic signed [DIST_W-1:0] dist_w;
  logic signed [AW-1:0] dsum, ddif;
  logic [AW-1:0]      ddif_abs;
  logic               hsat;
  logic [PW-1:0]      wm;
  logic [31:0]        wabs;
  logic signed [31:0] w_next;
  logic signed [63:0] p64, lin_term;
  logic signed [33:0] qs;
  logic signed [31:0] x_arc, y_arc, h_next;

  logic               trig_start, div_start, trig_done, div_done;
  logic signed [34:0] trig_angle;
  logic signed [31:0] trig_sin, trig_cos;
  logic [32:0]        quot;
  logic               qneg, ovf;

  always_comb begin
    case (cmd.op)
      OP_MUL_L:  begin mul_a = 33'(dl); mul_b = 33'(dist_per_count); end
      OP_MUL_R:  begin mul_a = 33'(dr); mul_b = 33'(dist_per_count); end
      OP_HLO:    begin mul_a = 33'(a_abs[HALF-1:0]); mul_b = 33'(inv_wheel_base); end
      OP_HHI:    begin mul_a = 33'(a_abs[WA-1:HALF]); mul_b = 33'(inv_wheel_base); end
      OP_MUL_SX: begin mul_a = 33'(v); mul_b = 33'(c0); end
      OP_MUL_SY: begin mul_a = 33'(v); mul_b = 33'(s0); end
      OP_MUL_NX: begin mul_a = 33'(v); mul_b = 33'(s1) - 33'(s0); end
      OP_MUL_NY: begin mul_a = 33'(v); mul_b = 33'(c1) - 33'(c0); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase

    dt_w     = $signed(tin - prev_time);
    p64      = prod[63:0];
    dist_w   = DIST_W'(p64 >>> SH);
    dsum     = AW'(dist_l) + AW'(dist_r);
    ddif     = AW'(dist_r) - AW'(dist_l);
    ddif_abs = ddif[AW-1] ? AW'(-ddif) : AW'(ddif);

    // heading change magnitude saturates once the product passes the limit
    hsat = hsat_pre || ((p_sum >> WA) != '0);
    wm   = (p_sum >> WSH_R) << WSH_L;
    if (hsat) begin
      wabs   = dneg ? 32'h80000000 : 32'h7FFFFFFF;
      w_next = dneg ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      wabs   = {1'b0, wm[30:0]};
      w_next = dneg ? -$signed({1'b0, wm[30:0]}) : $signed({1'b0, wm[30:0]});
    end

    lin_term = p64 >>> 30;
    qs = qneg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    if (ovf) begin
      x_arc = qneg ? 32'sh80000000 : 32'sh7FFFFFFF;
      y_arc = qneg ? 32'sh7FFFFFFF : 32'sh80000000;
    end else begin
      x_arc = sat32(64'(pos_x_reg) + 64'(qs));
      y_arc = sat32(64'(pos_y_reg) - 64'(qs));
    end
    h_next = wrap_angle(35'(heading_reg) + 35'(w));

    trig_start = (cmd.op == OP_T0_GO) || (cmd.op == OP_T1_GO);
    trig_angle = (cmd.op == OP_T1_GO) ? 35'(heading_reg) + 35'(w) : 35'(heading_reg);
    div_start  = (cmd.op == OP_DX_GO) || (cmd.op == OP_DY_GO);
  end

  ddo_cordic #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .angle   (trig_angle),
    .done    (trig_done),
    .sin_out (trig_sin),
    .cos_out (trig_cos)
  );

  ddo_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ((cmd.op == OP_DY_GO) ? numy : numx),
    .den   ({w, 1'b0}),
    .done  (div_done),
    .quot  (quot),
    .qneg  (qneg),
    .ovf   (ovf)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left   <= '0;
      prev_right  <= '0;
      prev_time   <= '0;
      pos_x_reg   <= '0;
      pos_y_reg   <= '0;
      heading_reg <= '0;
      kind        <= CMD_SAMPLE;
      upd         <= 1'b0;
      dt_pos      <= 1'b0;
      arc         <= 1'b0;
    end else begin
      if (cmd.load) begin
        kind <= in_kind;
        lin  <= in_left;
        rin  <= in_right;
        tin  <= in_time;
        upd  <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: begin
          pos_x_reg   <= '0;
          pos_y_reg   <= '0;
          heading_reg <= '0;
        end
        OP_INIT: begin
          pos_x_reg   <= '0;
          pos_y_reg   <= '0;
          heading_reg <= '0;
          prev_left   <= '0;
          prev_right  <= '0;
          prev_time   <= '0;
        end
        OP_DELTA: begin
          dl         <= $signed(lin - prev_left);
          dr         <= $signed(rin - prev_right);
          dt_pos     <= (dt_w > 0);
          upd        <= (dt_w > 0);
          prev_left  <= lin;
          prev_right <= rin;
          prev_time  <= tin;
        end
        OP_MUL_R:  dist_l <= dist_w;
        OP_DIST_R: dist_r <= dist_w;
        OP_PREP: begin
          v        <= sat32(64'(dsum >>> 1));
          a_abs    <= ddif_abs;
          dneg     <= ddif[AW-1];
          hsat_pre <= ((ddif_abs >> WA) != '0) && (inv_wheel_base != '0);
        end
        OP_HHI:  plo   <= prod[HALF+23:0];
        OP_HSUM: p_sum <= (PW'(prod[HI+23:0]) << HALF) + PW'(plo);
        OP_WFIN: begin
          w   <= w_next;
          arc <= wabs > 32'(straight_threshold);
        end
        OP_T0_CAP: begin
          s0 <= trig_sin;
          c0 <= trig_cos;
        end
        OP_T1_CAP: begin
          s1 <= trig_sin;
          c1 <= trig_cos;
        end
        OP_MUL_NY: numx <= prod[64:0];
        OP_NY_CAP: numy <= prod[64:0];
        OP_DX_CAP: pos_x_reg <= x_arc;
        OP_DY_CAP: begin
          pos_y_reg   <= y_arc;
          heading_reg <= h_next;
        end
        OP_MUL_SY: pos_x_reg <= sat32(64'(pos_x_reg) + lin_term);
        OP_SY_CAP: begin
          pos_y_reg   <= sat32(64'(pos_y_reg) + lin_term);
          heading_reg <= h_next;
        end
        OP_OUT: begin
          out_x       <= pos_x_reg;
          out_y       <= pos_y_reg;
          out_heading <= heading_reg;
          out_updated <= upd;
        end
        default: ;
      endcase
    end
  end

  assign stat.kind      = kind;
  assign stat.dt_pos    = dt_pos;
  assign stat.arc       = arc;
  assign stat.trig_done = trig_done;
  assign stat.div_done  = div_done;

endmodule

@@ rtl/ddo_ctrl.sv @@
module ddo_ctrl import ddo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ddo_stat_t stat,
  output ddo_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_CHECK   = 5'd2;
  localparam logic [4:0] S_MUL_L   = 5'd3;
  localparam logic [4:0] S_MUL_R   = 5'd4;
  localparam logic [4:0] S_DIST_R  = 5'd5;
  localparam logic [4:0] S_PREP    = 5'd6;
  localparam logic [4:0] S_HLO     = 5'd7;
  localparam logic [4:0] S_HHI     = 5'd8;
  localparam logic [4:0] S_HSUM    = 5'd9;
  localparam logic [4:0] S_WFIN    = 5'd10;
  localparam logic [4:0] S_T0_GO   = 5'd11;
  localparam logic [4:0] S_T0_WAIT = 5'd12;
  localparam logic [4:0] S_T1_GO   = 5'd13;
  localparam logic [4:0] S_T1_WAIT = 5'd14;
  localparam logic [4:0] S_MUL_NX  = 5'd15;
  localparam logic [4:0] S_MUL_NY  = 5'd16;
  localparam logic [4:0] S_NY_CAP  = 5'd17;
  localparam logic [4:0] S_DX_GO   = 5'd18;
  localparam logic [4:0] S_DX_WAIT = 5'd19;
  localparam logic [4:0] S_DY_GO   = 5'd20;
  localparam logic [4:0] S_DY_WAIT = 5'd21;
  localparam logic [4:0] S_MUL_SX  = 5'd22;
  localparam logic [4:0] S_MUL_SY  = 5'd23;
  localparam logic [4:0] S_SY_CAP  = 5'd24;
  localparam logic [4:0] S_OUT     = 5'd25;

  logic [4:0] state, state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_OUT;
        case (stat.kind)
          CMD_SAMPLE: begin
            cmd.op     = OP_DELTA;
            state_next = S_CHECK;
          end
          CMD_CLEAR: cmd.op = OP_CLEAR;
          CMD_INIT:  cmd.op = OP_INIT;
          default:   cmd.op = OP_NONE;
        endcase
      end
      S_CHECK:  state_next = stat.dt_pos ? S_MUL_L : S_OUT;
      S_MUL_L:  begin cmd.op = OP_MUL_L;  state_next = S_MUL_R;  end
      S_MUL_R:  begin cmd.op = OP_MUL_R;  state_next = S_DIST_R; end
      S_DIST_R: begin cmd.op = OP_DIST_R; state_next = S_PREP;   end
      S_PREP:   begin cmd.op = OP_PREP;   state_next = S_HLO;    end
      S_HLO:    begin cmd.op = OP_HLO;    state_next = S_HHI;    end
      S_HHI:    begin cmd.op = OP_HHI;    state_next = S_HSUM;   end
      S_HSUM:   begin cmd.op = OP_HSUM;   state_next = S_WFIN;   end
      S_WFIN:   begin cmd.op = OP_WFIN;   state_next = S_T0_GO;  end
      S_T0_GO:  begin cmd.op = OP_T0_GO;  state_next = S_T0_WAIT; end
      S_T0_WAIT: begin
        if (stat.trig_done) begin
          cmd.op     = OP_T0_CAP;
          state_next = stat.arc ? S_T1_GO : S_MUL_SX;
        end
      end
      S_T1_GO: begin cmd.op = OP_T1_GO; state_next = S_T1_WAIT; end
      S_T1_WAIT: begin
        if (stat.trig_done) begin
          cmd.op     = OP_T1_CAP;
          state_next = S_MUL_NX;
        end
      end
      S_MUL_NX: begin cmd.op = OP_MUL_NX; state_next = S_MUL_NY; end
      S_MUL_NY: begin cmd.op = OP_MUL_NY; state_next = S_NY_CAP; end
      S_NY_CAP: begin cmd.op = OP_NY_CAP; state_next = S_DX_GO;  end
      S_DX_GO:  begin cmd.op = OP_DX_GO;  state_next = S_DX_WAIT; end
      S_DX_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_DX_CAP;
          state_next = S_DY_GO;
        end
      end
      S_DY_GO: begin cmd.op = OP_DY_GO; state_next = S_DY_WAIT; end
      S_DY_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_DY_CAP;
          state_next = S_OUT;
        end
      end
      S_MUL_SX: begin cmd.op = OP_MUL_SX; state_next = S_MUL_SY; end
      S_MUL_SY: begin cmd.op = OP_MUL_SY; state_next = S_SY_CAP; end
      S_SY_CAP: begin cmd.op = OP_SY_CAP; state_next = S_OUT;    end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECODE)
    else $error("accepted item did not reach decode");

  a_trig_done_wait: assert property (@(posedge clk) disable iff (rst)
    stat.trig_done |-> (state == S_T0_WAIT || state == S_T1_WAIT))
    else $error("trig unit finished outside a wait state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_DX_WAIT || state == S_DY_WAIT))
    else $error("divider finished outside a wait state");

  a_out_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int REG_DIST_PER_COUNT = 0;
  localparam int REG_INV_WHEEL_BASE = 1;
  localparam int REG_STRAIGHT_THR = 2;
  localparam longint ANG_PI = 64'd1686629713;
  localparam longint ANG_HALF_PI = 64'd843314857;
  localparam longint ANG_TWO_PI = 64'd3373259426;
  localparam longint TRIG_GAIN = 64'h26DD3B6A;
  localparam int TRIG_STEPS = TRIG_ITERATIONS_DEF;
  localparam int POS_FRAC = POS_FRAC_BITS_DEF;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
    logic        upd;
  } pose_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    bit          typed;
    pose_t       want;
  } stim_row_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  differential_drive_odometry DUT (.*);

  // predictor copy of registers and state
  logic [31:0] cfg_dpc, cfg_iwb, cfg_thr;
  logic [31:0] last_l, last_r, last_t;
  logic [31:0] pos_x, pos_y, head;

  pose_t pending_poses[$];
  stim_row_t dir_rows[$];
  int mismatches;
  int sent_count;
  bit quiet;

  function automatic longint wrap_ang(longint a);
    longint m;
    m = (a + ANG_PI) % ANG_TWO_PI;
    if (m < 0) m += ANG_TWO_PI;
    return m - ANG_PI;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic sin_cos(input longint ang, output longint s, output longint c);
    bit flip;
    longint x, y, z, dx, dy;
    flip = 0;
    x = TRIG_GAIN;
    y = 0;
    ang = wrap_ang(ang);
    if (ang > ANG_HALF_PI) begin
      ang -= ANG_PI;
      flip = 1;
    end else if (ang < -ANG_HALF_PI) begin
      ang += ANG_PI;
      flip = 1;
    end
    z = ang * 2;
    for (int i = 0; i < TRIG_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint turn_of(longint diff);
    longint unsigned a, b, lim, p;
    longint w;
    a = diff < 0 ? longint'(-diff) : diff;
    b = 64'(cfg_iwb);
    lim = (64'd1 << (POS_FRAC + 18)) - 1;
    if (b != 0 && a > lim / b) w = 64'd2147483648;
    else begin
      p = a * b;
      if (POS_FRAC + 16 >= 29) p = p >> (POS_FRAC + 16 - 29);
      else p = p << (29 - POS_FRAC - 16);
      w = p;
    end
    return clamp32(diff < 0 ? -w : w);
  endfunction

  task automatic move_pose(input longint dl, input longint dr);
    longint dist_l, dist_r, v, w, th, x, y, s0, c0, s1, c1, aw;
    dist_l = (dl * longint'(cfg_dpc)) >>> (32 - POS_FRAC);
    dist_r = (dr * longint'(cfg_dpc)) >>> (32 - POS_FRAC);
    v = clamp32((dist_l + dist_r) >>> 1);
    w = turn_of(dist_r - dist_l);
    th = longint'($signed(head));
    x = longint'($signed(pos_x));
    y = longint'($signed(pos_y));
    aw = w < 0 ? -w : w;
    sin_cos(th, s0, c0);
    if (aw > longint'(cfg_thr)) begin
      sin_cos(th + w, s1, c1);
      x += (v * (s1 - s0)) / (2 * w);
      y -= (v * (c1 - c0)) / (2 * w);
    end else begin
      x += (v * c0) >>> 30;
      y += (v * s0) >>> 30;
    end
    pos_x = 32'(clamp32(x));
    pos_y = 32'(clamp32(y));
    head = 32'(wrap_ang(th + w));
  endtask

  task automatic odometry_step(input logic [1:0] cmd, input logic [31:0] l,
                               input logic [31:0] r, input logic [31:0] t,
                               output pose_t res);
    logic [31:0] dl, dr, dt;
    res.upd = 1'b0;
    if (cmd == CMD_SAMPLE) begin
      dl = l - last_l;
      dr = r - last_r;
      dt = t - last_t;
      last_l = l; last_r = r; last_t = t;
      if ($signed(dt) > 0) begin
        move_pose(longint'($signed(dl)), longint'($signed(dr)));
        res.upd = 1'b1;
      end
    end else if (cmd == CMD_CLEAR) begin
      pos_x = 0; pos_y = 0; head = 0;
    end else if (cmd == CMD_INIT) begin
      last_l = 0; last_r = 0; last_t = 0;
      pos_x = 0; pos_y = 0; head = 0;
    end
    res.x = pos_x;
    res.y = pos_y;
    res.h = head;
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [31:0] l, input logic [31:0] r,
                         input logic [31:0] t, input bit typed);
    stim_row_t row;
    row.cmd = cmd; row.l = l; row.r = r; row.t = t;
    row.typed = typed;
    row.want = '{x: 0, y: 0, h: 0, upd: 0};
    dir_rows.push_back(row);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic reg_write(input int idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 4'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_DIST_PER_COUNT: cfg_dpc = val;
      REG_INV_WHEEL_BASE: cfg_iwb = val & 32'hFFFFFF;
      default:            cfg_thr = val & 32'h1FFFFFFF;
    endcase
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] l, input logic [31:0] r,
                           input logic [31:0] t, input bit typed, input pose_t want);
    pose_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {t, r, l};
    do @(posedge clk); while (!s_axis_tready);
    odometry_step(cmd, l, r, t, res);
    pending_poses.push_back(typed ? want : res);
    sent_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receiver readiness, with one long hold-off to back up the input side
  initial begin
    bit held;
    held = 0;
    m_axis_tready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && sent_count >= 120) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk);
        held = 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 13) - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    pose_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", m_axis_tdata);
      end else begin
        want = pending_poses.pop_front();
        if (m_axis_tdata !== {want.h, want.y, want.x} || m_axis_tuser[0] !== want.upd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: exp x=%h y=%h h=%h upd=%b got x=%h y=%h h=%h upd=%b",
                     want.x, want.y, want.h, want.upd, m_axis_tdata[31:0],
                     m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser[0]);
        end
      end
    end
  end

  initial begin
    logic [31:0] cur_l, cur_r, cur_t, l, r, t;
    logic [1:0] cmd;
    int pick;
    int span;
    logic [31:0] phase_cfg[7][3];
    mismatches = 0;
    sent_count = 0;
    quiet = 0;
    rst <= 1;
    s_axis_tvalid <= 0; s_axis_tdata <= '0; s_axis_tuser <= '0;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
    cfg_dpc = DIST_PER_COUNT_RST;
    cfg_iwb = 32'(INV_WHEEL_BASE_RST);
    cfg_thr = 32'(STRAIGHT_THRESHOLD_RST);
    last_l = 0; last_r = 0; last_t = 0;
    pos_x = 0; pos_y = 0; head = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part under reset register values
    add_row(CMD_UNUSED, 32'h0, 32'h0, 32'h0, 1);
    add_row(CMD_SAMPLE, 32'h0, 32'h0, 32'h0, 1);
    add_row(CMD_SAMPLE, 32'd100, 32'd100, 32'd1, 0);
    add_row(CMD_SAMPLE, 32'd200, 32'd300, 32'd2, 0);
    add_row(CMD_SAMPLE, 32'd5000, 32'd900, 32'd3, 0);
    add_row(CMD_SAMPLE, 32'd5000, 32'd900, 32'd3, 0);
    add_row(CMD_SAMPLE, 32'd6000, 32'd1900, 32'd1, 0);
    add_row(CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    add_row(CMD_SAMPLE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    add_row(CMD_SAMPLE, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
    add_row(CMD_SAMPLE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000005, 0);
    add_row(CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    add_row(CMD_SAMPLE, 32'h80000000, 32'h80000000, 32'h80000010, 0);
    add_row(CMD_SAMPLE, 32'h80010000, 32'h7FFF0000, 32'h80000020, 0);
    add_row(CMD_SAMPLE, 32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 0);
    add_row(CMD_INIT, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1);
    add_row(CMD_SAMPLE, 32'hFFFFFFF0, 32'h00000010, 32'hFFFFFFFF, 1);
    add_row(CMD_SAMPLE, 32'h00000010, 32'hFFFFFFF0, 32'h00000004, 0);
    add_row(CMD_SAMPLE, 32'h00000400, 32'h00000400, 32'h00000008, 0);
    add_row(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 1);
    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].l, dir_rows[i].r, dir_rows[i].t,
                dir_rows[i].typed, dir_rows[i].want);

    phase_cfg[0] = '{DIST_PER_COUNT_RST, INV_WHEEL_BASE_RST, STRAIGHT_THRESHOLD_RST};
    phase_cfg[1] = '{32'hFFFFFFFF, 32'hFFFFFF, 32'h0};
    phase_cfg[2] = '{32'h1, 32'h1, 32'h1FFFFFFF};
    phase_cfg[3] = '{32'h0, 32'h0, STRAIGHT_THRESHOLD_RST};
    for (int p = 4; p < 7; p++)
      phase_cfg[p] = '{$urandom_range(1, 32'h00400000) * $urandom_range(1, 1024),
                       $urandom_range(1, 24'hFFFFFF), $urandom_range(0, 29'h1FFFFFFF)};

    cur_l = 0; cur_r = 0; cur_t = 0;
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      reg_write(REG_DIST_PER_COUNT, phase_cfg[p][0]);
      reg_write(REG_INV_WHEEL_BASE, phase_cfg[p][1]);
      reg_write(REG_STRAIGHT_THR, phase_cfg[p][2]);
      if (p == 6) quiet = 1;
      cur_l = last_l; cur_r = last_r; cur_t = last_t;
      for (int n = 0; n < 270; n++) begin
        pick = $urandom_range(0, 99);
        span = ($urandom_range(0, 9) == 0) ? 1 << 20 : 300;
        cmd = CMD_SAMPLE;
        l = cur_l + $urandom_range(0, 2 * span) - span;
        r = cur_r + $urandom_range(0, 2 * span) - span;
        t = cur_t + $urandom_range(1, 20);
        if (pick < 5) cmd = CMD_CLEAR;
        else if (pick < 8) cmd = CMD_INIT;
        else if (pick < 10) cmd = CMD_UNUSED;
        else if (pick < 15) t = cur_t - $urandom_range(0, 50);
        else if (pick < 20) begin
          l = $urandom; r = $urandom; t = $urandom;
        end
        if (cmd != CMD_SAMPLE) begin
          l = $urandom; r = $urandom; t = $urandom;
        end
        send_item(cmd, l, r, t, 0, '{x: 0, y: 0, h: 0, upd: 0});
        cur_l = last_l; cur_r = last_r; cur_t = last_t;
      end
    end

    s_axis_tvalid <= 0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
